// ===== sv/tf_pkg.sv =====
// Shared types, constants and helper functions for the Threefish-256 cipher.
`default_nettype none
package tf_pkg;
   localparam int WordBits     = 64;
   localparam int BlockWords   = 4;
   localparam int LastSubkey   = 18;
   localparam int StageCount   = 5 * LastSubkey + 1;
   localparam logic [63:0] Parity = 64'h1BD11BDAA9FC1A22;
   localparam logic FuncEncrypt = 1'b0;
   localparam logic FuncDecrypt = 1'b1;
   localparam int AddrBits     = 5;

   typedef logic [WordBits-1:0] tf_word_type;
   typedef tf_word_type [BlockWords-1:0] tf_block_type;
   typedef tf_word_type [BlockWords:0] tf_sched_type;

   typedef struct packed {
      logic         valid;
      logic         func;
      tf_word_type  tweak_low;
      tf_word_type  tweak_high;
      tf_block_type data;
   } tf_stage_type;

   function automatic int rot_amt(input int j, input int k);
      int r;
      r = 0;
      unique case (j)
         0: r = (k == 0) ? 14 : 16;
         1: r = (k == 0) ? 52 : 57;
         2: r = (k == 0) ? 23 : 40;
         3: r = (k == 0) ? 5  : 37;
         4: r = (k == 0) ? 25 : 33;
         5: r = (k == 0) ? 46 : 12;
         6: r = (k == 0) ? 58 : 22;
         default: r = 32;
      endcase
      return r;
   endfunction

   function automatic tf_word_type rotl(input tf_word_type x, input int n);
      return (x << n) | (x >> (WordBits - n));
   endfunction

   function automatic tf_word_type rotr(input tf_word_type x, input int n);
      return (x >> n) | (x << (WordBits - n));
   endfunction

   function automatic tf_word_type tweak_sel(input int n, input tf_word_type t0,
                                             input tf_word_type t1);
      tf_word_type r;
      r = t0 ^ t1;
      if (n == 0) r = t0;
      else if (n == 1) r = t1;
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== sv/tf_if.sv =====
// Request and response stream interfaces of the Threefish-256 cipher.
`default_nettype none
interface tf_req_if;
   logic                valid;
   logic                ready;
   logic                func;
   tf_pkg::tf_word_type tweak_low;
   tf_pkg::tf_word_type tweak_high;
   tf_pkg::tf_word_type data_word_0;
   tf_pkg::tf_word_type data_word_1;
   tf_pkg::tf_word_type data_word_2;
   tf_pkg::tf_word_type data_word_3;
   modport source (output valid, func, tweak_low, tweak_high, data_word_0, data_word_1,
                   data_word_2, data_word_3, input ready);
   modport sink (input valid, func, tweak_low, tweak_high, data_word_0, data_word_1,
                 data_word_2, data_word_3, output ready);
endinterface

interface tf_rsp_if;
   logic                valid;
   logic                ready;
   tf_pkg::tf_word_type out_word_0;
   tf_pkg::tf_word_type out_word_1;
   tf_pkg::tf_word_type out_word_2;
   tf_pkg::tf_word_type out_word_3;
   modport source (output valid, out_word_0, out_word_1, out_word_2, out_word_3,
                   input ready);
   modport sink (input valid, out_word_0, out_word_1, out_word_2, out_word_3,
                 output ready);
endinterface
`default_nettype wire

// ===== sv/threefish256_block_cipher.sv =====
// Top level of the pipelined Threefish-256 tweakable block cipher.
// Usage: a block word enters on req_bus with func (0 encrypt, 1 decrypt), a
// 128-bit tweak and four 64-bit data words; the result word leaves on rsp_bus.
// The 256-bit key is written through the csr_ port as four 64-bit registers at
// byte addresses 0, 8, 16 and 24; it may be changed only while the pipe is empty.
// The datapath is a chain of 91 cells: 19 subkey cells and 72 round cells, each
// one register stage.
// Throughput is one word per cycle; a new word is accepted every cycle while
// the output register is empty or being read.
// When rsp_bus.ready is low with a result waiting, the whole chain holds and
// req_bus.ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid flags and the key registers to zero; it takes effect
// at once and needs no clearing pass.
// Encryption and decryption may be mixed freely from word to word.
`default_nettype none
module threefish256_block_cipher #(
   parameter int AddrBits = tf_pkg::AddrBits
) (
   input  wire                 clock,
   input  wire                 reset,
   tf_req_if.sink              req_bus,
   tf_rsp_if.source            rsp_bus,
   input  wire                 csr_psel,
   input  wire                 csr_penable,
   input  wire                 csr_pwrite,
   input  wire [AddrBits-1:0]  csr_paddr,
   input  wire [63:0]          csr_pwdata,
   output logic [63:0]         csr_prdata,
   output logic                csr_pready
);
   localparam int N = tf_pkg::StageCount;

   tf_pkg::tf_word_type  key_ff [4];
   tf_pkg::tf_sched_type sched;
   tf_pkg::tf_stage_type stage [N+1];
   logic                 advance;
   logic [1:0]           csr_idx;
   logic                 csr_write;

   assign csr_idx    = csr_paddr[4:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = key_ff[csr_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else if (csr_write) begin
         key_ff[csr_idx] <= csr_pwdata;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) sched[i] = key_ff[i];
      sched[4] = tf_pkg::Parity ^ key_ff[0] ^ key_ff[1] ^ key_ff[2] ^ key_ff[3];
   end

   assign advance       = !stage[N].valid || rsp_bus.ready;
   assign req_bus.ready = advance;

   always_comb begin
      stage[0].valid      = req_bus.valid;
      stage[0].func       = req_bus.func;
      stage[0].tweak_low  = req_bus.tweak_low;
      stage[0].tweak_high = req_bus.tweak_high;
      stage[0].data[0]    = req_bus.data_word_0;
      stage[0].data[1]    = req_bus.data_word_1;
      stage[0].data[2]    = req_bus.data_word_2;
      stage[0].data[3]    = req_bus.data_word_3;
   end

   for (genvar g = 0; g <= tf_pkg::LastSubkey; g++) begin : g_group
      tf_key_cell #(.SubkeyIndex(g)) u_key (
         .clock(clock), .reset(reset), .advance(advance), .sched(sched),
         .stage_in(stage[g*5]), .stage_ff(stage[g*5+1])
      );
      if (g < tf_pkg::LastSubkey) begin : g_rounds
         for (genvar j = 0; j < 4; j++) begin : g_round
            tf_round_cell #(.RoundIndex(4*g + j)) u_round (
               .clock(clock), .reset(reset), .advance(advance),
               .stage_in(stage[g*5+1+j]), .stage_ff(stage[g*5+2+j])
            );
         end
      end
   end

   assign rsp_bus.valid      = stage[N].valid;
   assign rsp_bus.out_word_0 = stage[N].data[0];
   assign rsp_bus.out_word_1 = stage[N].data[1];
   assign rsp_bus.out_word_2 = stage[N].data[2];
   assign rsp_bus.out_word_3 = stage[N].data[3];

`ifndef NO_ASSERTIONS
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_bus.valid)
      else $error("result valid right after reset");
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> stage[1].valid)
      else $error("accepted word did not enter the pipe");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(stage[N].data))
      else $error("stalled result changed");
   a_key_write: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> key_ff[$past(csr_idx)] == $past(csr_pwdata))
      else $error("key register write lost");
`endif
endmodule
`default_nettype wire

// ===== sv/tf_key_cell.sv =====
// Pipeline cell that adds or removes one subkey of the key schedule.
`default_nettype none
module tf_key_cell #(
   parameter int SubkeyIndex = 0
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       advance,
   input  wire tf_pkg::tf_sched_type sched,
   input  wire tf_pkg::tf_stage_type stage_in,
   output tf_pkg::tf_stage_type      stage_ff
);
   localparam int EncS = SubkeyIndex;
   localparam int DecS = tf_pkg::LastSubkey - SubkeyIndex;
   localparam int E0 = EncS % 5;
   localparam int E1 = (EncS + 1) % 5;
   localparam int E2 = (EncS + 2) % 5;
   localparam int E3 = (EncS + 3) % 5;
   localparam int D0 = DecS % 5;
   localparam int D1 = (DecS + 1) % 5;
   localparam int D2 = (DecS + 2) % 5;
   localparam int D3 = (DecS + 3) % 5;
   localparam int ET1 = EncS % 3;
   localparam int ET2 = (EncS + 1) % 3;
   localparam int DT1 = DecS % 3;
   localparam int DT2 = (DecS + 1) % 3;

   tf_pkg::tf_block_type key_enc, key_dec;
   tf_pkg::tf_stage_type stage_in_d;

   always_comb begin
      key_enc[0] = sched[E0];
      key_enc[1] = sched[E1] + tf_pkg::tweak_sel(ET1, stage_in.tweak_low, stage_in.tweak_high);
      key_enc[2] = sched[E2] + tf_pkg::tweak_sel(ET2, stage_in.tweak_low, stage_in.tweak_high);
      key_enc[3] = sched[E3] + tf_pkg::tf_word_type'(EncS);
      key_dec[0] = sched[D0];
      key_dec[1] = sched[D1] + tf_pkg::tweak_sel(DT1, stage_in.tweak_low, stage_in.tweak_high);
      key_dec[2] = sched[D2] + tf_pkg::tweak_sel(DT2, stage_in.tweak_low, stage_in.tweak_high);
      key_dec[3] = sched[D3] + tf_pkg::tf_word_type'(DecS);
      stage_in_d = stage_in;
      for (int i = 0; i < tf_pkg::BlockWords; i++) begin
         if (stage_in.func == tf_pkg::FuncDecrypt) begin
            stage_in_d.data[i] = stage_in.data[i] - key_dec[i];
         end else begin
            stage_in_d.data[i] = stage_in.data[i] + key_enc[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (advance) begin
         stage_ff.func       <= stage_in_d.func;
         stage_ff.tweak_low  <= stage_in_d.tweak_low;
         stage_ff.tweak_high <= stage_in_d.tweak_high;
         stage_ff.data       <= stage_in_d.data;
      end
   end
endmodule
`default_nettype wire

// ===== sv/tf_round_cell.sv =====
// Pipeline cell that applies one forward or inverse mixing round.
`default_nettype none
module tf_round_cell #(
   parameter int RoundIndex = 0
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       advance,
   input  wire tf_pkg::tf_stage_type stage_in,
   output tf_pkg::tf_stage_type      stage_ff
);
   localparam int EncJ = RoundIndex % 8;
   localparam int DecJ = 7 - EncJ;
   localparam int EncP = (EncJ % 2 == 1) ? 3 : 1;
   localparam int EncQ = (EncJ % 2 == 1) ? 1 : 3;
   localparam int DecP = (DecJ % 2 == 1) ? 3 : 1;
   localparam int DecQ = (DecJ % 2 == 1) ? 1 : 3;
   localparam int ER0 = tf_pkg::rot_amt(EncJ, 0);
   localparam int ER1 = tf_pkg::rot_amt(EncJ, 1);
   localparam int DR0 = tf_pkg::rot_amt(DecJ, 0);
   localparam int DR1 = tf_pkg::rot_amt(DecJ, 1);

   tf_pkg::tf_block_type w, fwd, inv;

   always_comb begin
      w = stage_in.data;
      fwd = w;
      fwd[0]    = w[0] + w[EncP];
      fwd[EncP] = tf_pkg::rotl(w[EncP], ER0) ^ fwd[0];
      fwd[2]    = w[2] + w[EncQ];
      fwd[EncQ] = tf_pkg::rotl(w[EncQ], ER1) ^ fwd[2];
      inv = w;
      inv[DecP] = tf_pkg::rotr(w[DecP] ^ w[0], DR0);
      inv[0]    = w[0] - inv[DecP];
      inv[DecQ] = tf_pkg::rotr(w[DecQ] ^ w[2], DR1);
      inv[2]    = w[2] - inv[DecQ];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (advance) begin
         stage_ff.func       <= stage_in.func;
         stage_ff.tweak_low  <= stage_in.tweak_low;
         stage_ff.tweak_high <= stage_in.tweak_high;
         stage_ff.data <= (stage_in.func == tf_pkg::FuncDecrypt) ? inv : fwd;
      end
   end
endmodule
`default_nettype wire
